### rtl/deformable_window_max_pool_defines.svh
// Assertion macros shared by the deformable window max pool checker.
`ifndef DEFORMABLE_WINDOW_MAX_POOL_DEFINES_SVH
`define DEFORMABLE_WINDOW_MAX_POOL_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DWMP_ASSERT_IMP(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define DWMP_ASSERT_NEXT(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

### rtl/dwmp_pkg.sv
// Types and constants of the deformable window max pool.
package dwmp_pkg;

   localparam int MAX_MAP_DEFAULT = 64;
   localparam int WINDOW_RADIUS   = 5;
   localparam int VALUE_BITS      = 16;
   localparam int WIN_SIDE        = 2 * WINDOW_RADIUS + 1;
   localparam int WIN_COUNT       = WIN_SIDE * WIN_SIDE;

   localparam int MODE_W   = 2;
   localparam int POS_W    = 6;
   localparam int KW       = 7;
   localparam int SIZE_W   = 7;
   localparam int SUM_W    = VALUE_BITS + 1;
   localparam int STEP_W   = $clog2(WIN_SIDE);
   localparam int COORD_W  = 10;

   localparam logic [SIZE_W-1:0] MAP_SIZE_RESET = SIZE_W'(46);

   typedef enum logic [MODE_W-1:0] {
      MODE_PIXEL = 2'd0,
      MODE_BIAS  = 2'd1,
      MODE_QUERY = 2'd2
   } mode_type;

   typedef struct packed {
      logic wr_pixel;
      logic wr_bias;
      logic capture;
      logic issue;
      logic load;
      logic load_oor;
   } cmd_type;

   typedef struct packed {
      logic in_range;
      logic last_issue;
   } status_type;

endpackage

### rtl/dwmp_ram.sv
// Generic simple dual-port RAM with registered read.
module dwmp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/dwmp_ctrl.sv
// Controller of the deformable window max pool: item sequencing and result handshake.
module dwmp_ctrl
   import dwmp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [MODE_W-1:0] req_mode,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  status_type        status,
   output cmd_type           cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      oor_ff, oor_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      oor_in       = oor_ff;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (mode_type'(req_mode))
                  MODE_PIXEL: cmd.wr_pixel = 1'b1;
                  MODE_BIAS:  cmd.wr_bias  = 1'b1;
                  MODE_QUERY: begin
                     if (status.in_range) begin
                        cmd.capture = 1'b1;
                        oor_in      = 1'b0;
                        state_in    = ST_SCAN;
                     end else begin
                        oor_in   = 1'b1;
                        state_in = ST_FINISH;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            cmd.issue = 1'b1;
            if (status.last_issue) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load     = 1'b1;
               cmd.load_oor = oor_ff;
               rsp_valid_in = 1'b1;
               oor_in       = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         oor_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         oor_ff       <= oor_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

### rtl/dwmp_datapath.sv
// Datapath of the deformable window max pool: stores, window scan and running maximum.
module dwmp_datapath
   import dwmp_pkg::*;
#(
   parameter int MAX_MAP = MAX_MAP_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [SIZE_W-1:0]            csr_wdata,
   input  logic [POS_W-1:0]             req_row,
   input  logic [POS_W-1:0]             req_col,
   input  logic [KW-1:0]                req_offset_index,
   input  logic signed [VALUE_BITS-1:0] req_value,
   input  cmd_type                      cmd,
   output status_type                   status,
   output logic signed [SUM_W-1:0]      rsp_max_value,
   output logic [KW-1:0]                rsp_best_offset,
   output logic                         rsp_out_of_range
);

   localparam int AW = $clog2(MAX_MAP * MAX_MAP);
   localparam logic signed [COORD_W-1:0] MAX_S = COORD_W'(MAX_MAP);
   localparam logic signed [COORD_W-1:0] RAD_S = COORD_W'(WINDOW_RADIUS);

   logic [SIZE_W-1:0]  map_size_ff;
   logic [POS_W-1:0]   row_ff, col_ff;
   logic [STEP_W-1:0]  dr_ff, dr_in, dc_ff, dc_in;
   logic [KW-1:0]      k_ff, k_in;

   logic               acc_valid_ff, acc_first_ff, inmap_ff;
   logic [KW-1:0]      acc_k_ff;
   logic signed [SUM_W-1:0] best_ff;
   logic [KW-1:0]      best_k_ff;

   logic signed [SUM_W-1:0] max_ff;
   logic [KW-1:0]      best_offset_ff;
   logic               oor_ff;

   logic signed [COORD_W-1:0] size_s, r, c, qrow, qcol;
   logic               inmap;
   logic [AW-1:0]      scan_addr, wr_addr;
   logic               pix_we, bias_we;
   logic [VALUE_BITS-1:0] pix_rdata, bias_rdata;
   logic signed [SUM_W-1:0] pix_ext, sum;

   assign size_s = signed'(COORD_W'(map_size_ff));
   assign qrow   = signed'(COORD_W'(req_row));
   assign qcol   = signed'(COORD_W'(req_col));

   assign status.in_range   = (qrow < size_s) && (qcol < size_s) &&
                              (qrow < MAX_S) && (qcol < MAX_S);
   assign status.last_issue = (k_ff == KW'(WIN_COUNT - 1));

   assign r = signed'(COORD_W'(row_ff)) + signed'(COORD_W'(dr_ff)) - RAD_S;
   assign c = signed'(COORD_W'(col_ff)) + signed'(COORD_W'(dc_ff)) - RAD_S;
   assign inmap = (r >= 0) && (c >= 0) && (r < size_s) && (c < size_s) &&
                  (r < MAX_S) && (c < MAX_S);

   assign scan_addr = AW'(unsigned'(r)) * AW'(MAX_MAP) + AW'(unsigned'(c));
   assign wr_addr   = AW'(req_row) * AW'(MAX_MAP) + AW'(req_col);
   assign pix_we    = cmd.wr_pixel && (qrow < MAX_S) && (qcol < MAX_S);
   assign bias_we   = cmd.wr_bias && (req_offset_index < KW'(WIN_COUNT));

   dwmp_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (MAX_MAP * MAX_MAP)
   ) u_pixel_ram (
      .clock (clock),
      .we    (pix_we),
      .waddr (wr_addr),
      .wdata (req_value),
      .raddr (scan_addr),
      .rdata (pix_rdata)
   );

   dwmp_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (WIN_COUNT)
   ) u_bias_ram (
      .clock (clock),
      .we    (bias_we),
      .waddr (req_offset_index),
      .wdata (req_value),
      .raddr (k_ff),
      .rdata (bias_rdata)
   );

   // advance the window offset in row-major order
   always_comb begin
      dr_in = dr_ff;
      dc_in = dc_ff;
      k_in  = k_ff;
      if (cmd.capture) begin
         dr_in = '0;
         dc_in = '0;
         k_in  = '0;
      end else if (cmd.issue) begin
         k_in = k_ff + KW'(1);
         if (dc_ff == STEP_W'(WIN_SIDE - 1)) begin
            dc_in = '0;
            dr_in = dr_ff + STEP_W'(1);
         end else begin
            dc_in = dc_ff + STEP_W'(1);
         end
      end
   end

   assign pix_ext = inmap_ff ? SUM_W'(signed'(pix_rdata)) : '0;
   assign sum     = pix_ext + SUM_W'(signed'(bias_rdata));

   always_ff @(posedge clock) begin
      if (reset) begin
         map_size_ff  <= MAP_SIZE_RESET;
         acc_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            map_size_ff <= csr_wdata;
         end
         acc_valid_ff <= cmd.issue;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         row_ff <= req_row;
         col_ff <= req_col;
      end
      dr_ff        <= dr_in;
      dc_ff        <= dc_in;
      k_ff         <= k_in;
      acc_first_ff <= (k_ff == '0);
      inmap_ff     <= inmap;
      acc_k_ff     <= k_ff;
      // ties go to the later offset
      if (acc_valid_ff && (acc_first_ff || sum >= best_ff)) begin
         best_ff   <= sum;
         best_k_ff <= acc_k_ff;
      end
      if (cmd.load) begin
         max_ff         <= cmd.load_oor ? '0 : best_ff;
         best_offset_ff <= cmd.load_oor ? '0 : best_k_ff;
         oor_ff         <= cmd.load_oor;
      end
   end

   assign rsp_max_value    = max_ff;
   assign rsp_best_offset  = best_offset_ff;
   assign rsp_out_of_range = oor_ff;

endmodule

### rtl/deformable_window_max_pool.sv
// Top level of the deformable window max pool.
// Pixel and bias writes are taken in the idle state, which they do not leave. A query inside
// the map first scans the 11x11 window, one pixel and bias pair per cycle through the single
// read port of each memory, then drains the read register and then loads the output register,
// which raises rsp_valid. A query outside the map skips the scan and goes straight to the load.
// A result is loaded only once the output register is free, and the next item is taken as soon
// as it is loaded, even while that result still waits on rsp_ready. Both stores are undefined
// until written and need no clearing after reset.
module deformable_window_max_pool
   import dwmp_pkg::*;
#(
   parameter int MAX_MAP = MAX_MAP_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [SIZE_W-1:0]            csr_wdata,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [MODE_W-1:0]            req_mode,
   input  logic [POS_W-1:0]             req_row,
   input  logic [POS_W-1:0]             req_col,
   input  logic [KW-1:0]                req_offset_index,
   input  logic signed [VALUE_BITS-1:0] req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [SUM_W-1:0]      rsp_max_value,
   output logic [KW-1:0]                rsp_best_offset,
   output logic                         rsp_out_of_range
);

   cmd_type    cmd;
   status_type status;

   dwmp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_mode  (req_mode),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   dwmp_datapath #(
      .MAX_MAP (MAX_MAP)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .req_row          (req_row),
      .req_col          (req_col),
      .req_offset_index (req_offset_index),
      .req_value        (req_value),
      .cmd              (cmd),
      .status           (status),
      .rsp_max_value    (rsp_max_value),
      .rsp_best_offset  (rsp_best_offset),
      .rsp_out_of_range (rsp_out_of_range)
   );

endmodule

### rtl/dwmp_checker.sv
// Port-level checker of the deformable window max pool, bound to the top level.
`include "deformable_window_max_pool_defines.svh"

module dwmp_checker
   import dwmp_pkg::*;
(
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic [MODE_W-1:0]            req_mode,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic signed [SUM_W-1:0]      rsp_max_value,
   input logic [KW-1:0]                rsp_best_offset,
   input logic                         rsp_out_of_range
);

   `DWMP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_max_value) && $stable(rsp_best_offset) && $stable(rsp_out_of_range), "result item changed while stalled")

   `DWMP_ASSERT_IMP(a_oor_zero, clock, reset, rsp_valid && rsp_out_of_range, rsp_max_value == '0 && rsp_best_offset == '0, "out-of-range result carries data")

   `DWMP_ASSERT_IMP(a_offset_range, clock, reset, rsp_valid, rsp_best_offset < KW'(WIN_COUNT), "best offset beyond window")

   `DWMP_ASSERT_NEXT(a_query_busy, clock, reset, req_valid && req_ready && req_mode == MODE_QUERY, !req_ready, "query item did not occupy the block")

endmodule

bind deformable_window_max_pool dwmp_checker u_checker (.*);

### tb/tb_deformable_window_max_pool.sv
// Self-checking testbench for the deformable window max pool with its own window predictor.
module tb_deformable_window_max_pool;
   timeunit 1ns;
   timeprecision 1ps;
   import dwmp_pkg::*;

   localparam int CLK_HALF       = 6;
   localparam int RESET_CYCLES   = 8;
   localparam int MAP_MAX        = MAX_MAP_DEFAULT;
   localparam int SCAN_CYCLES    = 130;
   localparam int TIMEOUT_CYCLES = 1_500_000;
   localparam int RANDOM_ITEMS   = 1650;
   localparam int TOTAL_ITEMS    = 1850;
   localparam int REPORT_LIMIT   = 10;
   localparam int BLOCK_SIDE     = 8;
   localparam int SMALL_MAP      = 16;
   localparam int CENTER         = WINDOW_RADIUS * WIN_SIDE + WINDOW_RADIUS;
   localparam int INDEX_TOP      = 2 ** KW - 1;
   localparam int SIZE_TOP       = 2 ** SIZE_W - 1;
   localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
   localparam logic signed [VALUE_BITS-1:0] VALUE_TOP    = VALUE_BITS'(2 ** (VALUE_BITS - 1) - 1);
   localparam logic signed [VALUE_BITS-1:0] VALUE_BOTTOM = VALUE_BITS'(-(2 ** (VALUE_BITS - 1)));

   typedef struct packed {
      logic signed [SUM_W-1:0] max_value;
      logic [KW-1:0]           best_offset;
      logic                    out_of_range;
   } window_result_t;

   logic                         clock            = 1'b0;
   logic                         reset            = 1'b1;
   logic                         csr_we           = 1'b0;
   logic [SIZE_W-1:0]            csr_wdata        = '0;
   logic                         req_valid        = 1'b0;
   logic                         req_ready;
   logic [MODE_W-1:0]            req_mode         = '0;
   logic [POS_W-1:0]             req_row          = '0;
   logic [POS_W-1:0]             req_col          = '0;
   logic [KW-1:0]                req_offset_index = '0;
   logic signed [VALUE_BITS-1:0] req_value        = '0;
   logic                         rsp_valid;
   logic                         rsp_ready        = 1'b0;
   logic signed [SUM_W-1:0]      rsp_max_value;
   logic [KW-1:0]                rsp_best_offset;
   logic                         rsp_out_of_range;

   logic signed [VALUE_BITS-1:0] pixel_mem [MAP_MAX*MAP_MAX];
   bit                           pixel_set [MAP_MAX*MAP_MAX];
   logic signed [VALUE_BITS-1:0] bias_mem  [WIN_COUNT];
   bit                           bias_set  [WIN_COUNT];
   int unsigned                  map_cfg = int'(MAP_SIZE_RESET);

   window_result_t pending_maxima[$];
   int unsigned    items_taken = 0;
   int unsigned    bad_results = 0;
   bit             req_idling  = 1'b0;
   bit             rsp_idling  = 1'b0;
   int             rsp_stall   = 0;

   deformable_window_max_pool u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_row          (req_row),
      .req_col          (req_col),
      .req_offset_index (req_offset_index),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_max_value    (rsp_max_value),
      .rsp_best_offset  (rsp_best_offset),
      .rsp_out_of_range (rsp_out_of_range)
   );

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   function automatic int map_side();
      return (map_cfg > MAP_MAX) ? MAP_MAX : map_cfg;
   endfunction

   function automatic window_result_t window_max(input int row, input int col);
      window_result_t res;
      int side;
      int best;
      int sum;
      int r;
      int c;
      int pix;
      side = map_side();
      res  = '0;
      best = 0;
      if (row >= side || col >= side) begin
         res.out_of_range = 1'b1;
         return res;
      end
      for (int k = 0; k < WIN_COUNT; k++) begin
         r   = row + k / WIN_SIDE - WINDOW_RADIUS;
         c   = col + k % WIN_SIDE - WINDOW_RADIUS;
         pix = (r >= 0 && c >= 0 && r < side && c < side) ? int'(pixel_mem[r * MAP_MAX + c]) : 0;
         sum = pix + int'(bias_mem[k]);
         if (k == 0 || sum >= best) begin
            best            = sum;
            res.best_offset = KW'(k);
         end
      end
      res.max_value = SUM_W'(best);
      return res;
   endfunction

   function automatic bit window_loaded(input int row, input int col);
      int side;
      int r;
      int c;
      side = map_side();
      for (int k = 0; k < WIN_COUNT; k++) begin
         r = row + k / WIN_SIDE - WINDOW_RADIUS;
         c = col + k % WIN_SIDE - WINDOW_RADIUS;
         if (!bias_set[k])
            return 1'b0;
         if (r >= 0 && c >= 0 && r < side && c < side && !pixel_set[r * MAP_MAX + c])
            return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic logic signed [VALUE_BITS-1:0] rand_value();
      case ($urandom_range(0, 7))
         0:       return VALUE_TOP;
         1:       return VALUE_BOTTOM;
         2, 3:    return VALUE_BITS'(int'($urandom_range(0, 8)) - 4);
         default: return VALUE_BITS'($urandom);
      endcase
   endfunction

   task automatic report_mismatch(input string what, input window_result_t want,
                                  input window_result_t got);
      bad_results++;
      if (bad_results <= REPORT_LIMIT)
         $display("%0t %s: expected max %0d offset %0d oor %0b, got max %0d offset %0d oor %0b",
                  $realtime, what, want.max_value, want.best_offset, want.out_of_range,
                  got.max_value, got.best_offset, got.out_of_range);
   endtask

   always @(posedge clock) begin
      window_result_t want;
      window_result_t got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.max_value    = rsp_max_value;
         got.best_offset  = rsp_best_offset;
         got.out_of_range = rsp_out_of_range;
         if (pending_maxima.size() == 0) begin
            report_mismatch("result with no query pending", '0, got);
         end else begin
            want = pending_maxima.pop_front();
            if (got.max_value !== want.max_value || got.best_offset !== want.best_offset ||
                got.out_of_range !== want.out_of_range)
               report_mismatch("result mismatch", want, got);
         end
      end
   end

   always @(negedge clock) begin
      if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_ready <= 1'b0;
      end else if (rsp_idling && $urandom_range(0, 5) == 0) begin
         rsp_stall = $urandom_range(0, 7);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_item(input logic [MODE_W-1:0] mode, input logic [POS_W-1:0] row,
                            input logic [POS_W-1:0] col, input logic [KW-1:0] oidx,
                            input logic signed [VALUE_BITS-1:0] value);
      if (req_idling && $urandom_range(0, 3) == 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 7)) @(negedge clock);
      end
      @(negedge clock);
      req_valid        <= 1'b1;
      req_mode         <= mode;
      req_row          <= row;
      req_col          <= col;
      req_offset_index <= oidx;
      req_value        <= value;
      do @(posedge clock); while (!req_ready);
      items_taken++;
      case (mode)
         MODE_PIXEL: begin
            pixel_mem[row * MAP_MAX + col] = value;
            pixel_set[row * MAP_MAX + col] = 1'b1;
         end
         MODE_BIAS: begin
            if (oidx < WIN_COUNT) begin
               bias_mem[oidx] = value;
               bias_set[oidx] = 1'b1;
            end
         end
         MODE_QUERY: pending_maxima.push_back(window_max(row, col));
         default: ;
      endcase
   endtask

   task automatic write_pixel(input int row, input int col,
                              input logic signed [VALUE_BITS-1:0] value);
      send_item(MODE_PIXEL, POS_W'(row), POS_W'(col), KW'($urandom_range(0, INDEX_TOP)),
                value);
   endtask

   task automatic write_bias(input int idx, input logic signed [VALUE_BITS-1:0] value);
      send_item(MODE_BIAS, POS_W'($urandom_range(0, MAP_MAX - 1)),
                POS_W'($urandom_range(0, MAP_MAX - 1)), KW'(idx), value);
   endtask

   task automatic query_at(input int row, input int col);
      send_item(MODE_QUERY, POS_W'(row), POS_W'(col), KW'($urandom_range(0, INDEX_TOP)),
                rand_value());
   endtask

   task automatic send_spare();
      send_item(MODE_SPARE, POS_W'($urandom_range(0, MAP_MAX - 1)),
                POS_W'($urandom_range(0, MAP_MAX - 1)), KW'($urandom_range(0, INDEX_TOP)),
                rand_value());
   endtask

   task automatic wait_results_done();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_maxima.size() != 0) @(posedge clock);
      repeat (SCAN_CYCLES) @(posedge clock);
   endtask

   task automatic set_map_size(input int unsigned side_cfg);
      wait_results_done();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= SIZE_W'(side_cfg);
      @(negedge clock);
      csr_we    <= 1'b0;
      map_cfg = side_cfg;
   endtask

   task automatic pick_query(output bit found, output int row, output int col);
      int side;
      int start;
      int pos;
      side  = map_side();
      found = 1'b1;
      if (side < MAP_MAX && (side == 0 || $urandom_range(0, 5) == 0)) begin
         if ($urandom_range(0, 1)) begin
            row = $urandom_range(side, MAP_MAX - 1);
            col = $urandom_range(0, MAP_MAX - 1);
         end else begin
            row = $urandom_range(0, MAP_MAX - 1);
            col = $urandom_range(side, MAP_MAX - 1);
         end
         return;
      end
      for (int t = 0; t < 12; t++) begin
         row = $urandom_range(0, side - 1);
         col = $urandom_range(0, side - 1);
         if (window_loaded(row, col))
            return;
      end
      start = $urandom_range(0, side * side - 1);
      for (int n = 0; n < side * side; n++) begin
         pos = (start + n) % (side * side);
         row = pos / side;
         col = pos % side;
         if (window_loaded(row, col))
            return;
      end
      if (side < MAP_MAX) begin
         row = side;
         col = 0;
         return;
      end
      found = 1'b0;
   endtask

   task automatic run_phase(input bit quiet);
      int unsigned side_cfg;
      int side;
      int rbase;
      int cbase;
      int row;
      int col;
      bit found;
      case ($urandom_range(0, 19))
         0:       side_cfg = 0;
         1:       side_cfg = $urandom_range(MAP_MAX + 1, SIZE_TOP);
         2:       side_cfg = MAP_MAX;
         3, 4:    side_cfg = $urandom_range(SMALL_MAP + 1, MAP_MAX - 1);
         5, 6:    side_cfg = $urandom_range(BLOCK_SIDE + 1, SMALL_MAP);
         default: side_cfg = $urandom_range(1, BLOCK_SIDE);
      endcase
      set_map_size(side_cfg);
      side = map_side();
      if (!quiet) begin
         req_idling = ($urandom_range(0, 3) != 0);
         rsp_idling = ($urandom_range(0, 3) != 0);
      end
      if (side <= SMALL_MAP) begin
         for (int r = 0; r < side; r++)
            for (int c = 0; c < side; c++)
               write_pixel(r, c, rand_value());
      end else begin
         rbase = $urandom_range(0, 1) ? 0 : side - BLOCK_SIDE;
         cbase = $urandom_range(0, 1) ? 0 : side - BLOCK_SIDE;
         for (int r = 0; r < BLOCK_SIDE; r++)
            for (int c = 0; c < BLOCK_SIDE; c++)
               write_pixel(rbase + r, cbase + c, rand_value());
      end
      repeat ($urandom_range(5, 20)) write_bias($urandom_range(0, INDEX_TOP), rand_value());
      repeat ($urandom_range(30, 60)) begin
         case ($urandom_range(0, 19))
            10, 11, 12, 13, 14: begin
               if (side > 0 && $urandom_range(0, 3) != 0)
                  write_pixel($urandom_range(0, side - 1), $urandom_range(0, side - 1),
                              rand_value());
               else
                  write_pixel($urandom_range(0, MAP_MAX - 1), $urandom_range(0, MAP_MAX - 1),
                              rand_value());
            end
            15, 16: write_bias($urandom_range(0, INDEX_TOP), rand_value());
            17:     send_spare();
            18:     wait_results_done();
            default: begin
               pick_query(found, row, col);
               if (found)
                  query_at(row, col);
               else
                  write_pixel($urandom_range(0, MAP_MAX - 1), $urandom_range(0, MAP_MAX - 1),
                              rand_value());
            end
         endcase
      end
   endtask

   task automatic test_load_biases();
      for (int k = 0; k < WIN_COUNT; k++)
         write_bias(k, '0);
   endtask

   task automatic test_reset_size();
      for (int r = MAP_SIZE_RESET - WINDOW_RADIUS - 1; r < MAP_SIZE_RESET; r++)
         for (int c = MAP_SIZE_RESET - WINDOW_RADIUS - 1; c < MAP_SIZE_RESET; c++)
            write_pixel(r, c, rand_value());
      query_at(MAP_SIZE_RESET - 1, MAP_SIZE_RESET - 1);
      query_at(MAP_SIZE_RESET, MAP_SIZE_RESET - 1);
      query_at(MAP_SIZE_RESET - 1, MAP_SIZE_RESET);
      query_at(MAP_MAX - 1, MAP_MAX - 1);
   endtask

   task automatic test_tie_order();
      set_map_size(1);
      write_pixel(0, 0, '0);
      query_at(0, 0);
      write_pixel(0, 0, VALUE_BITS'(1));
      query_at(0, 0);
      write_pixel(0, 0, VALUE_BITS'(-1));
      query_at(0, 0);
      write_bias(WIN_COUNT - 1, VALUE_BITS'(-1));
      query_at(0, 0);
      query_at(1, 0);
      query_at(0, 1);
   endtask

   task automatic test_ignored_items();
      for (int idx = WIN_COUNT; idx <= INDEX_TOP; idx++)
         write_bias(idx, VALUE_TOP);
      repeat (3) send_spare();
      query_at(0, 0);
   endtask

   task automatic test_value_extremes();
      write_pixel(0, 0, VALUE_TOP);
      write_bias(CENTER, VALUE_TOP);
      query_at(0, 0);
      write_pixel(0, 0, VALUE_BOTTOM);
      query_at(0, 0);
   endtask

   task automatic test_all_minimum();
      set_map_size(WIN_SIDE);
      for (int r = 0; r < WIN_SIDE; r++)
         for (int c = 0; c < WIN_SIDE; c++)
            write_pixel(r, c, VALUE_BOTTOM);
      for (int k = 0; k < WIN_COUNT; k++)
         write_bias(k, VALUE_BOTTOM);
      query_at(WINDOW_RADIUS, WINDOW_RADIUS);
      query_at(0, 0);
      query_at(WIN_SIDE - 1, WIN_SIDE - 1);
      query_at(WIN_SIDE, 0);
   endtask

   task automatic test_map_size_edges();
      set_map_size(0);
      query_at(0, 0);
      query_at(MAP_MAX - 1, MAP_MAX - 1);
      set_map_size(SIZE_TOP);
      for (int r = MAP_MAX - WINDOW_RADIUS - 1; r < MAP_MAX; r++)
         for (int c = MAP_MAX - WINDOW_RADIUS - 1; c < MAP_MAX; c++)
            write_pixel(r, c, rand_value());
      query_at(MAP_MAX - 1, MAP_MAX - 1);
      set_map_size(MAP_MAX);
      query_at(MAP_MAX - 1, MAP_MAX - 1);
      set_map_size(MAP_MAX - 1);
      query_at(MAP_MAX - 1, MAP_MAX - 1);
      query_at(0, MAP_MAX - 1);
   endtask

   task automatic test_random();
      for (int k = 0; k < WIN_COUNT; k++)
         write_bias(k, rand_value());
      while (items_taken < RANDOM_ITEMS)
         run_phase(1'b0);
   endtask

   task automatic test_quiet_tail();
      req_idling = 1'b0;
      rsp_idling = 1'b0;
      do
         run_phase(1'b1);
      while (items_taken < TOTAL_ITEMS);
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      req_idling = 1'b1;
      rsp_idling = 1'b1;
      test_load_biases();
      test_reset_size();
      test_tie_order();
      test_ignored_items();
      test_value_extremes();
      test_all_minimum();
      test_map_size_edges();
      test_random();
      test_quiet_tail();
      wait_results_done();
      if (bad_results == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      repeat (TIMEOUT_CYCLES) @(posedge clock);
      $display("Verification failed");
      $finish;
   end

endmodule
